// ===== src/pvt_pkg.sv =====
// Shared types, constants and helper functions for the primitive vertex transform.
package pvt_pkg;

    localparam int FRAC = 16;
    localparam int EW   = 66;
    localparam int ACCW = 68;
    localparam int NUMW = 32 + FRAC;
    localparam int DCW  = $clog2(NUMW + 1);

    localparam logic [1:0] CMD_LOAD_PRI = 2'd0;
    localparam logic [1:0] CMD_LOAD_SEC = 2'd1;
    localparam logic [1:0] CMD_BEGIN    = 2'd2;
    localparam logic [1:0] CMD_VERTEX   = 2'd3;

    localparam logic [1:0] MODE_DEFAULT = 2'd0;
    localparam logic [1:0] MODE_XSPLIT  = 2'd1;
    localparam logic [1:0] MODE_ZSPLIT  = 2'd2;

    localparam logic signed [31:0] ONE_Q  = 32'sd1 <<< FRAC;
    localparam logic signed [31:0] HALF_Q = 32'sd1 <<< (FRAC - 1);

    localparam logic [EW-1:0] NORM_HI = EW'(64'd1 << 30);
    localparam logic [EW-1:0] NORM_LO = EW'(64'd1 << 29);

    typedef struct packed {
        logic            start;
        logic [NUMW-1:0] numer;
        logic [31:0]     denom;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic [3:0] d;
    } cof_idx_t;

    // element indices of cofactor k: a*b - c*d
    function automatic cof_idx_t cof_idx(input logic [3:0] k);
        cof_idx_t r;
        case (k)
            4'd0:    r = '{4'd5,  4'd10, 4'd6,  4'd9};
            4'd1:    r = '{4'd6,  4'd8,  4'd4,  4'd10};
            4'd2:    r = '{4'd4,  4'd9,  4'd5,  4'd8};
            4'd3:    r = '{4'd9,  4'd2,  4'd10, 4'd1};
            4'd4:    r = '{4'd10, 4'd0,  4'd8,  4'd2};
            4'd5:    r = '{4'd8,  4'd1,  4'd9,  4'd0};
            4'd6:    r = '{4'd1,  4'd6,  4'd2,  4'd5};
            4'd7:    r = '{4'd2,  4'd4,  4'd0,  4'd6};
            4'd8:    r = '{4'd0,  4'd5,  4'd1,  4'd4};
            default: r = '{4'd0,  4'd0,  4'd0,  4'd0};
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] hi;
        logic signed [ACCW-1:0] lo;
        hi = ACCW'(32'sh7fffffff);
        lo = ACCW'(32'sh80000000);
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] e);
        return e[EW-1] ? EW'(-e) : EW'(e);
    endfunction

    function automatic logic signed [31:0] scale_elem(input logic signed [EW-1:0] e,
                                                      input logic [6:0] dn,
                                                      input logic [6:0] up);
        logic [EW-1:0] m;
        logic [EW-1:0] s;
        m = mag(e);
        s = (m >> dn) << up;
        return e[EW-1] ? -$signed(s[31:0]) : $signed(s[31:0]);
    endfunction

endpackage

// ===== src/pvt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pvt_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pvt_pkg::div_req_t        req,
    output logic [pvt_pkg::NUMW-1:0] quotient,
    output pvt_pkg::div_stat_t       stat
);

    logic [pvt_pkg::NUMW-1:0] num_reg;
    logic [31:0]              rem_reg;
    logic [31:0]              den_reg;
    logic [pvt_pkg::DCW-1:0]  cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, num_reg[pvt_pkg::NUMW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                num_reg  <= req.numer;
                den_reg  <= req.denom;
                rem_reg  <= '0;
                cnt_reg  <= pvt_pkg::DCW'(pvt_pkg::NUMW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                num_reg <= {num_reg[pvt_pkg::NUMW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pvt_pkg::DCW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== src/primitive_vertex_transform_core.sv =====
// Vertex transform: loads, begin (normal matrix derivation) and vertices on one multiplier.
// A load writes one matrix element. A begin derives the normal matrix of both matrices
// in turn. A vertex runs the multiply steps, the normalizer shift steps, a square root
// and three divides (only the multiply steps when the normal is invalid); no overlap
// of items.
// One result register decouples the output; a vertex waits there only if it is still full.
// rst_n clears control state and sets both matrices and normal matrices to identity.
module primitive_vertex_transform_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [3:0]         index,
    input  logic signed [31:0] value,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic signed [31:0] in_nx,
    input  logic signed [31:0] in_ny,
    input  logic signed [31:0] in_nz,
    input  logic signed [31:0] in_u,
    input  logic signed [31:0] in_v,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_nx,
    output logic signed [31:0] out_ny,
    output logic signed [31:0] out_nz,
    output logic signed [31:0] out_u,
    output logic signed [31:0] out_v,
    output logic               normal_invalid
);

    typedef enum logic [4:0] {
        S_IDLE, D_P1, D_P2, D_P3, D_NORM, D_APPLY, D_DET, D_FIN,
        V_POS, V_NRM, V_NORM, V_APPLY, V_SS, V_SQA, V_SQR, V_DIV, V_DWAIT,
        V_UV0, V_UV1, V_UV2, V_OUT
    } state_t;

    localparam int EW   = pvt_pkg::EW;
    localparam int ACCW = pvt_pkg::ACCW;

    state_t                  state_reg;
    logic signed [31:0]      mat_reg  [2][16];
    logic signed [31:0]      nmat_reg [2][9];
    logic [1:0]              mode_reg;
    logic signed [31:0]      scale_reg;
    logic [1:0]              mark_reg;
    logic                    sel_reg;
    logic [3:0]              k_reg;
    logic [1:0]              c_reg;
    logic [1:0]              r_reg;
    logic signed [EW-1:0]    elem_reg [9];
    logic [EW-1:0]           nw_reg;
    logic [6:0]              dn_reg;
    logic [6:0]              up_reg;
    logic                    ok_reg;
    logic signed [ACCW-1:0]  acc_reg;
    logic signed [31:0]      vec_reg [3];
    logic signed [31:0]      nrm_reg [3];
    logic signed [31:0]      u_reg;
    logic signed [31:0]      v_reg;
    logic signed [31:0]      res_reg [8];
    logic                    inv_reg;
    logic [63:0]             sqv_reg;
    logic [63:0]             sqr_reg;
    logic [63:0]             sqb_reg;
    logic                    ovalid_reg;
    logic signed [64:0]      prod_reg;

    logic signed [32:0]      mul_a;
    logic signed [31:0]      mul_b;
    logic signed [ACCW-1:0]  dot_sum;
    logic signed [ACCW-1:0]  pos_init;
    pvt_pkg::cof_idx_t       ci;
    logic [3:0]              nidx;
    logic [3:0]              pidx;
    logic [3:0]              cidx;
    logic [3:0]              ridx;
    logic signed [32:0]      xs;
    logic signed [32:0]      zs;
    logic signed [31:0]      xh;
    logic signed [31:0]      zh;
    logic                    second;
    logic [EW-1:0]           dot_mag;
    pvt_pkg::div_req_t       dreq;
    pvt_pkg::div_stat_t      dstat;
    logic [pvt_pkg::NUMW-1:0] quot;
    logic signed [ACCW-1:0]  qs;
    logic                    accept;
    logic                    out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign out_free = !ovalid_reg || !out_stall;

    assign ci       = pvt_pkg::cof_idx(k_reg);
    assign nidx     = (c_reg == 2'd3) ? 4'd0 : 4'({r_reg, 1'b0}) + 4'(r_reg) + 4'(c_reg);
    assign pidx     = {r_reg, c_reg};
    assign cidx     = {2'd0, c_reg};
    assign ridx     = {2'd0, r_reg};
    assign dot_sum  = acc_reg + ACCW'(prod_reg);
    assign dot_mag  = pvt_pkg::mag(EW'(dot_sum));
    assign pos_init = (ACCW'(mat_reg[sel_reg][{r_reg, 2'd3}]) <<< pvt_pkg::FRAC)
                      + ACCW'(pvt_pkg::HALF_Q);

    // split-mode shift and matrix choice
    assign xs = 33'(in_x) + 33'(pvt_pkg::HALF_Q);
    assign zs = 33'(in_z) + 33'(pvt_pkg::HALF_Q);
    assign xh = pvt_pkg::sat32(ACCW'(xs));
    assign zh = pvt_pkg::sat32(ACCW'(zs));
    always_comb
    begin
        case (mode_reg)
            pvt_pkg::MODE_XSPLIT: second = xh > pvt_pkg::HALF_Q;
            pvt_pkg::MODE_ZSPLIT: second = zh > pvt_pkg::HALF_Q;
            default:              second = in_y > 32'sd0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            D_P1:
            begin
                mul_a = 33'(mat_reg[sel_reg][ci.a]);
                mul_b = mat_reg[sel_reg][ci.b];
            end
            D_P2:
            begin
                mul_a = 33'(mat_reg[sel_reg][ci.c]);
                mul_b = mat_reg[sel_reg][ci.d];
            end
            D_DET:
            begin
                if (c_reg != 2'd3)
                begin
                    mul_a = 33'(mat_reg[sel_reg][{2'd0, c_reg}]);
                    mul_b = elem_reg[cidx][31:0];
                end
            end
            V_POS:
            begin
                if (c_reg != 2'd3)
                begin
                    mul_a = 33'(mat_reg[sel_reg][pidx]);
                    mul_b = vec_reg[c_reg];
                end
            end
            V_NRM:
            begin
                if (c_reg != 2'd3)
                begin
                    mul_a = 33'(nmat_reg[sel_reg][nidx]);
                    mul_b = nrm_reg[c_reg];
                end
            end
            V_SS:
            begin
                if (c_reg != 2'd3)
                begin
                    mul_a = 33'($signed(elem_reg[cidx][31:0]));
                    mul_b = elem_reg[cidx][31:0];
                end
            end
            V_UV0:
            begin
                mul_a = 33'(u_reg) + 33'(pvt_pkg::ONE_Q);
                mul_b = scale_reg;
            end
            V_UV1:
            begin
                mul_a = 33'(v_reg) + 33'(pvt_pkg::ONE_Q);
                mul_b = scale_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        dreq.start = state_reg == V_DIV;
        dreq.numer = (pvt_pkg::NUMW'(pvt_pkg::mag(elem_reg[ridx])) << pvt_pkg::FRAC)
                     + pvt_pkg::NUMW'(sqr_reg[31:1]);
        dreq.denom = sqr_reg[31:0];
    end

    pvt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .quotient (quot),
        .stat     (dstat)
    );

    assign qs = elem_reg[ridx][EW-1] ? -ACCW'(quot) : ACCW'(quot);

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            for (int s = 0; s < 2; s++)
            begin
                for (int i = 0; i < 16; i++)
                    mat_reg[s][i] <= (i % 5 == 0) ? pvt_pkg::ONE_Q : 32'sd0;
                for (int i = 0; i < 9; i++)
                    nmat_reg[s][i] <= (i % 4 == 0) ? pvt_pkg::ONE_Q : 32'sd0;
            end
            mode_reg   <= pvt_pkg::MODE_DEFAULT;
            scale_reg  <= '0;
            mark_reg   <= '0;
            sel_reg    <= 1'b0;
            k_reg      <= '0;
            c_reg      <= '0;
            r_reg      <= '0;
            for (int i = 0; i < 9; i++)
                elem_reg[i] <= '0;
            nw_reg     <= '0;
            dn_reg     <= '0;
            up_reg     <= '0;
            ok_reg     <= 1'b0;
            acc_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vec_reg[i] <= '0;
                nrm_reg[i] <= '0;
            end
            u_reg      <= '0;
            v_reg      <= '0;
            for (int i = 0; i < 8; i++)
                res_reg[i] <= '0;
            inv_reg    <= 1'b0;
            sqv_reg    <= '0;
            sqr_reg    <= '0;
            sqb_reg    <= '0;
            ovalid_reg <= 1'b0;
            out_x          <= '0;
            out_y          <= '0;
            out_z          <= '0;
            out_nx         <= '0;
            out_ny         <= '0;
            out_nz         <= '0;
            out_u          <= '0;
            out_v          <= '0;
            normal_invalid <= 1'b0;
        end
        else
        begin
            if (state_reg == V_OUT && out_free)
                ovalid_reg <= 1'b1;
            else if (!out_stall)
                ovalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd)
                            pvt_pkg::CMD_LOAD_PRI: mat_reg[0][index] <= value;
                            pvt_pkg::CMD_LOAD_SEC: mat_reg[1][index] <= value;
                            pvt_pkg::CMD_BEGIN:
                            begin
                                mode_reg  <= (index <= 4'd2) ? index[1:0]
                                                             : pvt_pkg::MODE_DEFAULT;
                                scale_reg <= value;
                                sel_reg   <= 1'b0;
                                k_reg     <= '0;
                                nw_reg    <= '0;
                                state_reg <= D_P1;
                            end
                            default:
                            begin
                                vec_reg[0] <= (mode_reg == pvt_pkg::MODE_XSPLIT) ? xh : in_x;
                                vec_reg[1] <= in_y;
                                vec_reg[2] <= (mode_reg == pvt_pkg::MODE_ZSPLIT) ? zh : in_z;
                                nrm_reg[0] <= in_nx;
                                nrm_reg[1] <= in_ny;
                                nrm_reg[2] <= in_nz;
                                u_reg      <= in_u;
                                v_reg      <= in_v;
                                sel_reg    <= second;
                                r_reg      <= '0;
                                c_reg      <= '0;
                                state_reg  <= V_POS;
                            end
                        endcase
                    end
                end

                // cofactor k = a*b - c*d over states D_P1, D_P2 and D_P3
                D_P1: state_reg <= D_P2;
                D_P2:
                begin
                    acc_reg   <= ACCW'(prod_reg);
                    state_reg <= D_P3;
                end
                D_P3:
                begin
                    elem_reg[k_reg] <= EW'(acc_reg - ACCW'(prod_reg));
                    nw_reg <= nw_reg | pvt_pkg::mag(EW'(acc_reg - ACCW'(prod_reg)));
                    dn_reg <= '0;
                    up_reg <= '0;
                    if (k_reg == 4'd8)
                    begin
                        k_reg     <= '0;
                        state_reg <= D_NORM;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= D_P1;
                    end
                end
                D_NORM:
                begin
                    if (nw_reg == '0)
                    begin
                        ok_reg    <= 1'b0;
                        state_reg <= D_FIN;
                    end
                    else if (nw_reg >= pvt_pkg::NORM_HI)
                    begin
                        nw_reg <= nw_reg >> 1;
                        dn_reg <= dn_reg + 7'd1;
                    end
                    else if (nw_reg < pvt_pkg::NORM_LO)
                    begin
                        nw_reg <= nw_reg << 1;
                        up_reg <= up_reg + 7'd1;
                    end
                    else
                        state_reg <= D_APPLY;
                end
                D_APPLY:
                begin
                    elem_reg[k_reg] <= EW'(pvt_pkg::scale_elem(elem_reg[k_reg], dn_reg, up_reg));
                    if (k_reg == 4'd8)
                    begin
                        ok_reg    <= 1'b1;
                        c_reg     <= '0;
                        state_reg <= D_DET;
                    end
                    else
                        k_reg <= k_reg + 4'd1;
                end
                D_DET:
                begin
                    acc_reg <= (c_reg == 2'd0) ? '0 : dot_sum;
                    c_reg   <= c_reg + 2'd1;
                    if (c_reg == 2'd3)
                        state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    if (!ok_reg || acc_reg == '0)
                    begin
                        for (int i = 0; i < 9; i++)
                            nmat_reg[sel_reg][i] <= '0;
                        mark_reg[sel_reg] <= 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < 9; i++)
                            nmat_reg[sel_reg][i] <= acc_reg[ACCW-1] ? -elem_reg[i][31:0]
                                                                    : elem_reg[i][31:0];
                        mark_reg[sel_reg] <= 1'b0;
                    end
                    if (!sel_reg)
                    begin
                        sel_reg   <= 1'b1;
                        k_reg     <= '0;
                        nw_reg    <= '0;
                        state_reg <= D_P1;
                    end
                    else
                        state_reg <= S_IDLE;
                end

                V_POS:
                begin
                    acc_reg <= (c_reg == 2'd0) ? pos_init : dot_sum;
                    c_reg   <= c_reg + 2'd1;
                    if (c_reg == 2'd3)
                    begin
                        res_reg[{1'b0, r_reg}] <= pvt_pkg::sat32(dot_sum >>> pvt_pkg::FRAC);
                        if (r_reg == 2'd2)
                        begin
                            r_reg     <= '0;
                            nw_reg    <= '0;
                            state_reg <= V_NRM;
                        end
                        else
                            r_reg <= r_reg + 2'd1;
                    end
                end
                V_NRM:
                begin
                    acc_reg <= (c_reg == 2'd0) ? '0 : dot_sum;
                    c_reg   <= c_reg + 2'd1;
                    if (c_reg == 2'd3)
                    begin
                        elem_reg[ridx] <= EW'(dot_sum);
                        nw_reg <= nw_reg | dot_mag;
                        dn_reg <= '0;
                        up_reg <= '0;
                        if (r_reg == 2'd2)
                        begin
                            r_reg <= '0;
                            if (mark_reg[sel_reg] || (nw_reg | dot_mag) == '0)
                            begin
                                res_reg[3] <= '0;
                                res_reg[4] <= '0;
                                res_reg[5] <= '0;
                                inv_reg    <= 1'b1;
                                state_reg  <= V_UV0;
                            end
                            else
                            begin
                                inv_reg   <= 1'b0;
                                state_reg <= V_NORM;
                            end
                        end
                        else
                            r_reg <= r_reg + 2'd1;
                    end
                end
                V_NORM:
                begin
                    if (nw_reg >= pvt_pkg::NORM_HI)
                    begin
                        nw_reg <= nw_reg >> 1;
                        dn_reg <= dn_reg + 7'd1;
                    end
                    else if (nw_reg < pvt_pkg::NORM_LO)
                    begin
                        nw_reg <= nw_reg << 1;
                        up_reg <= up_reg + 7'd1;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        state_reg <= V_APPLY;
                    end
                end
                V_APPLY:
                begin
                    elem_reg[k_reg] <= EW'(pvt_pkg::scale_elem(elem_reg[k_reg], dn_reg, up_reg));
                    if (k_reg == 4'd2)
                    begin
                        c_reg     <= '0;
                        state_reg <= V_SS;
                    end
                    else
                        k_reg <= k_reg + 4'd1;
                end
                V_SS:
                begin
                    acc_reg <= (c_reg == 2'd0) ? '0 : dot_sum;
                    c_reg   <= c_reg + 2'd1;
                    if (c_reg == 2'd3)
                    begin
                        sqv_reg   <= dot_sum[63:0];
                        sqr_reg   <= '0;
                        sqb_reg   <= 64'd1 << 62;
                        state_reg <= V_SQA;
                    end
                end
                V_SQA:
                begin
                    if (sqb_reg > sqv_reg)
                        sqb_reg <= sqb_reg >> 2;
                    else
                        state_reg <= V_SQR;
                end
                V_SQR:
                begin
                    if (sqb_reg != '0)
                    begin
                        if (sqv_reg >= sqr_reg + sqb_reg)
                        begin
                            sqv_reg <= sqv_reg - (sqr_reg + sqb_reg);
                            sqr_reg <= (sqr_reg >> 1) + sqb_reg;
                        end
                        else
                            sqr_reg <= sqr_reg >> 1;
                        sqb_reg <= sqb_reg >> 2;
                    end
                    else
                    begin
                        r_reg     <= '0;
                        state_reg <= V_DIV;
                    end
                end
                V_DIV: state_reg <= V_DWAIT;
                V_DWAIT:
                begin
                    if (dstat.done)
                    begin
                        res_reg[3'd3 + {1'b0, r_reg}] <= pvt_pkg::sat32(qs);
                        if (r_reg == 2'd2)
                            state_reg <= V_UV0;
                        else
                        begin
                            r_reg     <= r_reg + 2'd1;
                            state_reg <= V_DIV;
                        end
                    end
                end
                V_UV0: state_reg <= V_UV1;
                V_UV1:
                begin
                    res_reg[6] <= pvt_pkg::sat32((ACCW'(prod_reg) + ACCW'(pvt_pkg::HALF_Q))
                                                 >>> pvt_pkg::FRAC);
                    state_reg  <= V_UV2;
                end
                V_UV2:
                begin
                    res_reg[7] <= pvt_pkg::sat32((ACCW'(prod_reg) + ACCW'(pvt_pkg::HALF_Q))
                                                 >>> pvt_pkg::FRAC);
                    state_reg  <= V_OUT;
                end
                V_OUT:
                begin
                    // hold until the result register is free
                    if (out_free)
                    begin
                        out_x          <= res_reg[0];
                        out_y          <= res_reg[1];
                        out_z          <= res_reg[2];
                        out_nx         <= res_reg[3];
                        out_ny         <= res_reg[4];
                        out_nz         <= res_reg[5];
                        out_u          <= res_reg[6];
                        out_v          <= res_reg[7];
                        normal_invalid <= inv_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ovalid_reg;

endmodule

// ===== src/pvt_checker.sv =====
// Port-level checks for the vertex transform core, bound to the top level.
module pvt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         cmd,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_nx,
    input logic signed [31:0] out_ny,
    input logic signed [31:0] out_nz,
    input logic               normal_invalid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_x))
        else $error("stalled result changed");

    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && normal_invalid |-> out_nx == 0 && out_ny == 0 && out_nz == 0)
        else $error("invalid normal not zero");

    a_vtx_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == pvt_pkg::CMD_VERTEX |=> in_stall)
        else $error("vertex item did not occupy the core");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd != pvt_pkg::CMD_VERTEX |=> !$rose(out_valid))
        else $error("result appeared after a non-vertex item");

endmodule

bind primitive_vertex_transform_core pvt_checker u_pvt_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x          (out_x),
    .out_nx         (out_nx),
    .out_ny         (out_ny),
    .out_nz         (out_nz),
    .normal_invalid (normal_invalid)
);

// ===== tb/tb_primitive_vertex_transform_core.sv =====
// Self-checking testbench for primitive_vertex_transform_core.
`timescale 1ns / 1ps

module tb_primitive_vertex_transform_core;

    typedef logic signed [69:0] wide_t;
    typedef wide_t vec9_t [9];

    typedef struct {
        logic [1:0]         cmd;
        logic [3:0]         index;
        logic signed [31:0] value;
        logic signed [31:0] x, y, z, nx, ny, nz, u, v;
    } mesh_item_t;

    typedef struct {
        logic signed [31:0] x, y, z, nx, ny, nz, u, v;
        logic               inval;
    } vertex_out_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         cmd;
    logic [3:0]         index;
    logic signed [31:0] value;
    logic signed [31:0] in_x, in_y, in_z, in_nx, in_ny, in_nz, in_u, in_v;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_x, out_y, out_z, out_nx, out_ny, out_nz, out_u, out_v;
    logic               normal_invalid;

    mesh_item_t  pending_items[$];
    vertex_out_t expected_vertices[$];
    int          mismatches;
    int          cycle_count;

    // shadow state of the block
    logic signed [31:0] pri_mat[16];
    logic signed [31:0] sec_mat[16];
    wide_t              pri_nrm[9];
    wide_t              sec_nrm[9];
    logic [1:0]         mode_q;
    logic signed [31:0] tex_scale;
    logic [1:0]         singular_q;

    primitive_vertex_transform_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL primitive_vertex_transform_core");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(input wide_t v);
        if (v > 70'sd2147483647)
            return 32'sh7fffffff;
        if (v < -70'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic bit block_normalize(input vec9_t src, input int n, output vec9_t dst);
        wide_t m;
        wide_t mg[9];
        int    dn;
        int    up;
        m  = 0;
        dn = 0;
        up = 0;
        for (int i = 0; i < 9; i++)
        begin
            mg[i]  = (src[i] < 0) ? -src[i] : src[i];
            dst[i] = 0;
            if (i < n && mg[i] > m)
                m = mg[i];
        end
        if (m == 0)
            return 1'b0;
        while (m >= (70'sd1 <<< 30))
        begin
            m = m >>> 1;
            dn++;
        end
        while (m < (70'sd1 <<< 29))
        begin
            m = m <<< 1;
            up++;
        end
        for (int i = 0; i < n; i++)
            dst[i] = (src[i] < 0) ? -((mg[i] >>> dn) <<< up) : ((mg[i] >>> dn) <<< up);
        return 1'b1;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > val)
            b = b >> 2;
        while (b != 0)
        begin
            if (val >= r + b)
            begin
                val = val - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic derive_normal_matrix(input logic signed [31:0] mat[16], output wide_t nrm[9],
                                        input int bitpos);
        vec9_t cof;
        vec9_t sc;
        wide_t det;
        bit    ok;
        int    i1, i2, j1, j2;
        for (int i = 0; i < 3; i++)
        begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++)
            begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                cof[i*3+j] = wide_t'(mat[i1*4+j1]) * wide_t'(mat[i2*4+j2])
                           - wide_t'(mat[i1*4+j2]) * wide_t'(mat[i2*4+j1]);
            end
        end
        ok  = block_normalize(cof, 9, sc);
        det = 0;
        for (int j = 0; j < 3; j++)
            det += wide_t'(mat[j]) * sc[j];
        if (!ok || det == 0)
        begin
            for (int i = 0; i < 9; i++)
                nrm[i] = 0;
            singular_q[bitpos] = 1'b1;
        end
        else
        begin
            singular_q[bitpos] = 1'b0;
            for (int i = 0; i < 9; i++)
                nrm[i] = (det < 0) ? -sc[i] : sc[i];
        end
    endtask

    task automatic apply_mesh_item(input mesh_item_t it);
        vertex_out_t        e;
        logic signed [31:0] mat[16];
        wide_t              nrm[9];
        wide_t              pos[3];
        wide_t              nin[3];
        wide_t              acc;
        wide_t              hlf;
        vec9_t              tv;
        vec9_t              ts;
        logic [63:0]        ssum;
        logic [63:0]        len;
        logic [63:0]        mg;
        wide_t              q;
        logic signed [31:0] res[3];
        bit                 second;
        hlf = wide_t'(pvt_pkg::HALF_Q);
        case (it.cmd)
            pvt_pkg::CMD_LOAD_PRI: pri_mat[it.index] = it.value;
            pvt_pkg::CMD_LOAD_SEC: sec_mat[it.index] = it.value;
            pvt_pkg::CMD_BEGIN:
            begin
                mode_q    = (it.index <= 4'd2) ? it.index[1:0] : pvt_pkg::MODE_DEFAULT;
                tex_scale = it.value;
                derive_normal_matrix(pri_mat, pri_nrm, 0);
                derive_normal_matrix(sec_mat, sec_nrm, 1);
            end
            default:
            begin
                pos[0] = it.x;
                pos[1] = it.y;
                pos[2] = it.z;
                if (mode_q == pvt_pkg::MODE_XSPLIT)
                begin
                    pos[0] = clamp32(pos[0] + hlf);
                    second = pos[0] > hlf;
                end
                else if (mode_q == pvt_pkg::MODE_ZSPLIT)
                begin
                    pos[2] = clamp32(pos[2] + hlf);
                    second = pos[2] > hlf;
                end
                else
                    second = pos[1] > 0;
                if (second)
                begin
                    mat = sec_mat;
                    nrm = sec_nrm;
                end
                else
                begin
                    mat = pri_mat;
                    nrm = pri_nrm;
                end
                for (int r = 0; r < 3; r++)
                begin
                    acc = (wide_t'(mat[r*4+3]) <<< pvt_pkg::FRAC) + hlf;
                    for (int c = 0; c < 3; c++)
                        acc += wide_t'(mat[r*4+c]) * pos[c];
                    res[r] = clamp32(acc >>> pvt_pkg::FRAC);
                end
                e.x = res[0];
                e.y = res[1];
                e.z = res[2];
                nin[0] = it.nx;
                nin[1] = it.ny;
                nin[2] = it.nz;
                for (int i = 0; i < 9; i++)
                    tv[i] = 0;
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        tv[r] += nrm[r*3+c] * nin[c];
                e.nx = 0;
                e.ny = 0;
                e.nz = 0;
                e.inval = 1'b1;
                if (!singular_q[second] && block_normalize(tv, 3, ts))
                begin
                    e.inval = 1'b0;
                    ssum = 0;
                    for (int r = 0; r < 3; r++)
                        ssum += 64'(ts[r] * ts[r]);
                    len = int_sqrt(ssum);
                    for (int r = 0; r < 3; r++)
                    begin
                        mg = 64'((ts[r] < 0) ? -ts[r] : ts[r]);
                        q = wide_t'(((mg << pvt_pkg::FRAC) + (len >> 1)) / len);
                        res[r] = clamp32((ts[r] < 0) ? -q : q);
                    end
                    e.nx = res[0];
                    e.ny = res[1];
                    e.nz = res[2];
                end
                acc = (wide_t'(it.u) + wide_t'(pvt_pkg::ONE_Q)) * wide_t'(tex_scale) + hlf;
                e.u = clamp32(acc >>> pvt_pkg::FRAC);
                acc = (wide_t'(it.v) + wide_t'(pvt_pkg::ONE_Q)) * wide_t'(tex_scale) + hlf;
                e.v = clamp32(acc >>> pvt_pkg::FRAC);
                expected_vertices = {expected_vertices, e};
            end
        endcase
    endtask

    // mostly moderate values, sometimes any 32-bit pattern
    function automatic logic signed [31:0] pick_q16(input int span);
        int k;
        k = $urandom_range(0, 99);
        if (k < 8)
            return $urandom;
        if (k < 11)
            return (k == 8) ? 32'sh7fffffff : (k == 9) ? 32'sh80000000 : 32'sd0;
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic add_item(input logic [1:0] c, input logic [3:0] idx, input logic signed [31:0] val);
        mesh_item_t it;
        it.cmd   = c;
        it.index = idx;
        it.value = val;
        it.x  = pick_q16(1 << 20);
        it.y  = pick_q16(1 << 20);
        it.z  = pick_q16(1 << 20);
        it.nx = pick_q16(1 << 17);
        it.ny = pick_q16(1 << 17);
        it.nz = pick_q16(1 << 17);
        it.u  = pick_q16(1 << 17);
        it.v  = pick_q16(1 << 17);
        pending_items = {pending_items, it};
    endtask

    task automatic add_vertex(input logic signed [31:0] x, y, z, nx, ny, nz, u, v);
        mesh_item_t it;
        it = '{pvt_pkg::CMD_VERTEX, 4'd0, 32'sd0, x, y, z, nx, ny, nz, u, v};
        pending_items = {pending_items, it};
    endtask

    // driver: advance on acceptance, hold while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_mesh_item('{cmd, index, value, in_x, in_y, in_z, in_nx, in_ny, in_nz,
                                  in_u, in_v});
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0 &&
                    ((cycle_count > 40000 && cycle_count < 70000) || $urandom_range(0, 99) >= 18))
                begin
                    cmd      <= pending_items[0].cmd;
                    index    <= pending_items[0].index;
                    value    <= pending_items[0].value;
                    in_x     <= pending_items[0].x;
                    in_y     <= pending_items[0].y;
                    in_z     <= pending_items[0].z;
                    in_nx    <= pending_items[0].nx;
                    in_ny    <= pending_items[0].ny;
                    in_nz    <= pending_items[0].nz;
                    in_u     <= pending_items[0].u;
                    in_v     <= pending_items[0].v;
                    in_valid <= 1'b1;
                    void'(pending_items.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off, one stretch without stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= 15000 && cycle_count < 20000)
                out_stall <= 1'b1;
            else if (cycle_count > 40000 && cycle_count < 70000)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 18);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        vertex_out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_vertices.size() == 0)
            begin
                $display("%0t: unexpected vertex output, expected none, actual x=%h",
                         $time, out_x);
                mismatches++;
            end
            else
            begin
                e = expected_vertices.pop_front();
                if ({out_x, out_y, out_z, out_nx, out_ny, out_nz, out_u, out_v, normal_invalid}
                    !== {e.x, e.y, e.z, e.nx, e.ny, e.nz, e.u, e.v, e.inval})
                begin
                    $display("%0t: vertex mismatch expected %h %h %h n %h %h %h uv %h %h inv %b",
                             $time, e.x, e.y, e.z, e.nx, e.ny, e.nz, e.u, e.v, e.inval);
                    $display("%0t:                 actual %h %h %h n %h %h %h uv %h %h inv %b",
                             $time, out_x, out_y, out_z, out_nx, out_ny, out_nz, out_u, out_v,
                             normal_invalid);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic signed [31:0] one;
        int                 nverts;
        one        = pvt_pkg::ONE_Q;
        mismatches = 0;
        rst_n      = 1'b0;
        {cmd, index, value, in_x, in_y, in_z, in_nx, in_ny, in_nz, in_u, in_v} = '0;
        for (int i = 0; i < 16; i++)
        begin
            pri_mat[i] = (i % 5 == 0) ? pvt_pkg::ONE_Q : 32'sd0;
            sec_mat[i] = pri_mat[i];
        end
        for (int i = 0; i < 9; i++)
        begin
            pri_nrm[i] = (i % 4 == 0) ? wide_t'(pvt_pkg::ONE_Q) : 0;
            sec_nrm[i] = pri_nrm[i];
        end
        mode_q     = pvt_pkg::MODE_DEFAULT;
        tex_scale  = 0;
        singular_q = 2'b00;

        // directed: reset identities, extremes, all modes, singular matrix, zero normal
        add_vertex(32'sh7fffffff, 32'sd1, 32'sh80000000, one, 0, 0, 32'sh7fffffff, 32'sh80000000);
        add_vertex(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 0);
        add_item(pvt_pkg::CMD_BEGIN, 4'(pvt_pkg::MODE_XSPLIT), one <<< 2);
        add_vertex(32'sh7fffffff, 0, 0, 32'sh80000000, 32'sh7fffffff, 1, 32'sh80000000, -one);
        add_vertex(0, 0, 0, 1, 0, 0, 32'sh7fffffff, 32'sh7fffffff);
        add_vertex(32'sd1, 0, 0, 0, 0, 1, 0, 0);
        add_item(pvt_pkg::CMD_BEGIN, 4'(pvt_pkg::MODE_ZSPLIT), 32'sh80000000);
        add_vertex(0, 0, 32'sh7fffffff, 0, one, 0, 32'sh7fffffff, 32'sh80000000);
        add_vertex(0, 0, 32'sd0, 0, one, 0, one, one);
        add_item(pvt_pkg::CMD_LOAD_PRI, 4'd0, 32'sh80000000);
        add_item(pvt_pkg::CMD_LOAD_PRI, 4'd5, 32'sh7fffffff);
        add_item(pvt_pkg::CMD_LOAD_PRI, 4'd10, 32'sh80000000);
        add_item(pvt_pkg::CMD_LOAD_PRI, 4'd3, 32'sh7fffffff);
        add_item(pvt_pkg::CMD_LOAD_SEC, 4'd0, 32'sd0);
        add_item(pvt_pkg::CMD_LOAD_SEC, 4'd15, 32'sh80000000);
        add_item(pvt_pkg::CMD_BEGIN, 4'd3, 32'sh7fffffff);
        add_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, one, one, one, 0, -one);
        add_vertex(32'sh80000000, 32'sd1, 32'sh80000000, one, one, one, one, 0);
        add_item(pvt_pkg::CMD_BEGIN, 4'd15, one);
        add_vertex(0, 0, 0, 0, 0, 0, 0, 0);
        add_vertex(one, 32'sd5, one, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 0);

        // random primitives: some loads, a begin, then a run of vertices
        nverts = 0;
        while (nverts < 720)
        begin
            repeat ($urandom_range(0, 12))
                add_item(2'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                         pick_q16(1 << 18));
            add_item(pvt_pkg::CMD_BEGIN,
                     ($urandom_range(0, 9) == 0) ? 4'($urandom_range(3, 15))
                                                 : 4'($urandom_range(0, 2)),
                     pick_q16(1 << 19));
            repeat ($urandom_range(1, 20))
            begin
                add_item(pvt_pkg::CMD_VERTEX, 4'($urandom), $urandom);
                nverts++;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (in_valid || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatches == 0 && expected_vertices.size() == 0)
            $display("PASS primitive_vertex_transform_core");
        else
            $display("FAIL primitive_vertex_transform_core");
        $finish;
    end

endmodule
